### sv/ipv6_interface_address_table_assert.svh
// Assertion macros for the checker file.
`ifndef IPV6_INTERFACE_ADDRESS_TABLE_ASSERT_SVH
`define IPV6_INTERFACE_ADDRESS_TABLE_ASSERT_SVH
// Assert that a condition holds at every rising clock edge outside reset.
`define IAT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define IAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/iat_pkg.sv
package iat_pkg;
  localparam logic [3:0] FN_BIND = 4'd0;
  localparam logic [3:0] FN_RESET_IF = 4'd1;
  localparam logic [3:0] FN_ID_BY_LINK = 4'd2;
  localparam logic [3:0] FN_ADD = 4'd3;
  localparam logic [3:0] FN_REMOVE = 4'd4;
  localparam logic [3:0] FN_FIND_ALL = 4'd5;
  localparam logic [3:0] FN_FIND_IF = 4'd6;
  localparam logic [3:0] FN_PFX_IF = 4'd7;
  localparam logic [3:0] FN_PFX_ALL = 4'd8;
  localparam logic [3:0] FN_SRC_IF = 4'd9;
  localparam logic [3:0] FN_SRC_ALL = 4'd10;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVAL = 3'd1;
  localparam logic [2:0] ST_BOUND = 3'd2;
  localparam logic [2:0] ST_NOBUF = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [2:0] FL_ANYCAST = 3'd1;
  localparam logic [2:0] FL_MULTICAST = 3'd2;
  localparam logic [2:0] FL_LINK_LOCAL = 3'd4;

  typedef struct packed {
    logic [3:0] func;
    logic [2:0] if_index;
    logic [7:0] link_id;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic is_anycast;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] hit_if;
    logic [2:0] hit_slot;
    logic [63:0] hit_addr_high;
    logic [63:0] hit_addr_low;
    logic [7:0] prefix_len;
    logic loopback_hit;
  } rsp_t;
endpackage

### sv/iat_req_if.sv
interface iat_req_if import iat_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/iat_rsp_if.sv
interface iat_rsp_if import iat_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/iat_lzc.sv
// Leading matching bits of two 128-bit words: count of leading zeros of the XOR.
module iat_lzc import iat_pkg::*; (
  input logic [127:0] a,
  input logic [127:0] b,
  output logic [7:0] len
);
  logic [127:0] x;
  logic found;

  // Priority scan from the top bit down.
  always_comb begin
    x = a ^ b;
    len = 8'd128;
    found = 1'b0;
    for (int n = 0; n < 128; n++) begin
      if (!found && x[127 - n]) begin
        len = 8'(n);
        found = 1'b1;
      end
    end
  end
endmodule

### sv/ipv6_interface_address_table.sv
// IPv6 interface address table. One request is taken at a time. The block
// then scans its address slots one per cycle through a single shared
// compare and prefix-length unit. Bind and link-id lookup scan the IF_COUNT
// link-id registers and stop early at a match. Operations on one interface
// scan its ADDR_SLOTS slots. Searches over all interfaces scan all
// IF_COUNT*ADDR_SLOTS slots. A slot scan ends by evaluating its last
// registered read, and the S_DONE state then forms the result and does
// any table write. The block is ready again in the cycle after the result
// is taken. The result is held in an output register until taken.
module ipv6_interface_address_table import iat_pkg::*; #(
  parameter int IF_COUNT = 4,
  parameter int ADDR_SLOTS = 4
) (
  input logic clk,
  input logic rst,
  iat_req_if.sink req,
  iat_rsp_if.source rsp
);
  localparam int SLOTS = IF_COUNT * ADDR_SLOTS;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = (IF_COUNT > 1) ? $clog2(IF_COUNT) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  req_t r;
  logic [7:0] bound [IF_COUNT];
  logic [63:0] mem_h [SLOTS];
  logic [63:0] mem_l [SLOTS];
  logic [2:0] mem_f [SLOTS];
  logic [SLOTS-1:0] used;   // slot holds a non-zero address
  logic [CW-1:0] cnt;
  logic [CW-1:0] last;
  logic [SW-1:0] base;
  logic [SW-1:0] addr;
  logic [63:0] rd_h, rd_l;
  logic [127:0] rd_val;
  logic rd_used;
  logic rd_vld;
  logic [SW-1:0] rd_addr;
  logic [2:0] scan_if, scan_k;
  logic [2:0] rd_if, rd_k;
  logic found;
  logic [SW-1:0] best_s;
  logic [2:0] best_if, best_k;
  logic [7:0] best_len;
  logic [63:0] best_h, best_l;
  logic [7:0] m_len;
  rsp_t out;

  logic [IW:0] ifx_w;
  logic if_ok;
  logic op_unspec, op_loop, op_mcast;
  logic [127:0] opnd;
  logic in_all, in_ifscan;

  assign opnd = {r.addr_high, r.addr_low};
  assign op_unspec = (opnd == 128'd0);
  assign op_loop = (opnd == 128'd1);
  assign op_mcast = (r.addr_high[63:56] == 8'hff);
  assign ifx_w = (IW + 1)'(r.if_index);
  assign if_ok = ({1'b0, r.if_index} < 4'(IF_COUNT)) && (bound[ifx_w[IW-1:0]] != 8'd0);

  // Scan range of the incoming item, decoded at acceptance.
  assign in_all = (req.payload.func == FN_FIND_ALL) || (req.payload.func == FN_PFX_ALL) ||
                  (req.payload.func == FN_SRC_ALL);
  assign in_ifscan = (req.payload.func == FN_BIND) || (req.payload.func == FN_ID_BY_LINK);

  iat_lzc u_lzc (.a({rd_h, rd_l}), .b(opnd), .len(m_len));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.payload = out;
  assign addr = base + SW'(cnt);

  // Slot memory: registered read of one slot per cycle.
  always_ff @(posedge clk) begin
    rd_h <= mem_h[addr];
    rd_l <= mem_l[addr];
    rd_addr <= addr;
    rd_if <= scan_if;
    rd_k <= scan_k;
  end
  assign rd_used = used[rd_addr];
  // A free slot reads as the unspecified address.
  assign rd_val = rd_used ? {rd_h, rd_l} : 128'd0;

  logic is_all, is_pfx, with_mc, is_ifscan;
  assign is_all = (r.func == FN_FIND_ALL) || (r.func == FN_PFX_ALL) ||
                  (r.func == FN_SRC_ALL);
  assign is_pfx = (r.func == FN_PFX_IF) || (r.func == FN_PFX_ALL) ||
                  (r.func == FN_SRC_IF) || (r.func == FN_SRC_ALL);
  assign with_mc = (r.func == FN_PFX_IF) || (r.func == FN_PFX_ALL);
  assign is_ifscan = (r.func == FN_BIND) || (r.func == FN_ID_BY_LINK);

  logic [IW-1:0] cnt_if;
  assign cnt_if = cnt[IW-1:0];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      rd_vld <= 1'b0;
      for (int i = 0; i < IF_COUNT; i++) bound[i] <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.payload;
            cnt <= '0;
            found <= 1'b0;
            best_len <= 8'd0;
            best_s <= '0;
            rd_vld <= 1'b0;
            out <= '0;
            base <= in_all ? '0 : SW'(ADDR_SLOTS * req.payload.if_index);
            last <= in_ifscan ? CW'(IF_COUNT) :
                    (in_all ? CW'(SLOTS) : CW'(ADDR_SLOTS));
            scan_if <= in_all ? 3'd0 : req.payload.if_index;
            scan_k <= 3'd0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (is_ifscan) begin
            // Interface scan reads the link-id registers directly.
            if (!found && cnt != CW'(IF_COUNT)) begin
              if (bound[cnt_if] == r.link_id) begin
                found <= 1'b1; best_s <= SW'(cnt); best_len <= 8'd2;
              end else if (r.func == FN_BIND && bound[cnt_if] == 8'd0) begin
                found <= 1'b1; best_s <= SW'(cnt); best_len <= 8'd0;
              end
              cnt <= cnt + 1'b1;
            end else state <= S_DONE;
          end else begin
            // Issue one slot read per cycle; its data is evaluated in the next cycle.
            rd_vld <= (cnt != last);
            if (cnt != last) begin
              cnt <= cnt + 1'b1;
              if (scan_k == 3'(ADDR_SLOTS - 1)) begin
                scan_k <= 3'd0;
                scan_if <= scan_if + 3'd1;
              end else scan_k <= scan_k + 3'd1;
            end else state <= S_DONE;
            // Evaluate the slot read in the previous cycle.
            if (rd_vld) begin
              if (is_pfx) begin
                if (rd_used && (with_mc || rd_h[63:56] != 8'hff) && m_len > best_len) begin
                  best_len <= m_len; best_s <= rd_addr; best_h <= rd_h; best_l <= rd_l;
                  best_if <= rd_if; best_k <= rd_k;
                end
              end else if (!found) begin
                if (r.func == FN_ADD && !rd_used) begin
                  found <= 1'b1; best_s <= rd_addr; best_len <= 8'd1;
                end else if (rd_val == opnd) begin
                  found <= 1'b1; best_s <= rd_addr; best_len <= 8'd0;
                  best_if <= rd_if; best_k <= rd_k;
                end
              end
            end
          end
        end
        S_DONE: begin
          state <= S_OUT;
          unique case (r.func)
            FN_BIND: begin
              if (r.link_id == 8'd0) out.status <= ST_INVAL;
              else if (!found) out.status <= ST_NOBUF;
              else if (best_len == 8'd2) out.status <= ST_BOUND;
              else begin
                bound[best_s[IW-1:0]] <= r.link_id;
                out.hit_if <= 3'(best_s[IW-1:0]);
              end
            end
            FN_ID_BY_LINK: begin
              if (r.link_id == 8'd0 || !found) out.status <= ST_NOTFOUND;
              else out.hit_if <= 3'(best_s[IW-1:0]);
            end
            FN_RESET_IF: begin
              if (!if_ok) out.status <= ST_NOTFOUND;
              else begin
                bound[ifx_w[IW-1:0]] <= 8'd0;
                for (int k = 0; k < ADDR_SLOTS; k++)
                  used[SW'(ADDR_SLOTS * r.if_index + k)] <= 1'b0;
                base <= SW'(ADDR_SLOTS * r.if_index);
                cnt <= '0;
              end
            end
            FN_ADD: begin
              if (!if_ok) out.status <= ST_NOTFOUND;
              else if (op_unspec || op_loop || (op_mcast && r.is_anycast))
                out.status <= ST_INVAL;
              else if (!found) out.status <= ST_NOBUF;
              else begin
                out.hit_slot <= 3'(best_s - SW'(ADDR_SLOTS * r.if_index));
                if (best_len == 8'd1) begin
                  used[best_s] <= 1'b1;
                  mem_h[best_s] <= r.addr_high;
                  mem_l[best_s] <= r.addr_low;
                  mem_f[best_s] <= (r.is_anycast ? FL_ANYCAST : 3'd0) |
                                   (op_mcast ? FL_MULTICAST : 3'd0) |
                                   ((r.addr_high[63:54] == 10'h3fa) ? FL_LINK_LOCAL : 3'd0);
                end
              end
            end
            FN_REMOVE: begin
              if (!if_ok) out.status <= ST_NOTFOUND;
              else if (found) begin
                out.hit_slot <= 3'(best_s - SW'(ADDR_SLOTS * r.if_index));
                used[best_s] <= 1'b0;
                mem_h[best_s] <= '0;
                mem_l[best_s] <= '0;
                mem_f[best_s] <= '0;
              end
            end
            FN_FIND_ALL: begin
              if (op_unspec) out.status <= ST_NOTFOUND;
              else if (op_loop) begin
                out.loopback_hit <= 1'b1; out.hit_addr_low <= 64'd1;
              end else if (!found) out.status <= ST_NOTFOUND;
              else begin
                out.hit_if <= best_if;
                out.hit_slot <= best_k;
                out.hit_addr_high <= r.addr_high; out.hit_addr_low <= r.addr_low;
              end
            end
            FN_FIND_IF: begin
              if (!if_ok || op_unspec || op_loop || !found) out.status <= ST_NOTFOUND;
              else begin
                out.hit_if <= r.if_index;
                out.hit_slot <= 3'(best_s - SW'(ADDR_SLOTS * r.if_index));
                out.hit_addr_high <= r.addr_high; out.hit_addr_low <= r.addr_low;
              end
            end
            FN_PFX_IF, FN_SRC_IF, FN_PFX_ALL, FN_SRC_ALL: begin
              if ((!is_all && !if_ok) || best_len == 8'd0) out.status <= ST_NOTFOUND;
              else begin
                out.hit_if <= best_if;
                out.hit_slot <= best_k;
                out.hit_addr_high <= best_h; out.hit_addr_low <= best_l;
                out.prefix_len <= best_len;
              end
            end
            default: out.status <= ST_INVAL;
          endcase
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/iat_checker.sv
`include "ipv6_interface_address_table_assert.svh"
module iat_checker import iat_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_payload
);
  // One request in flight: no acceptance while a result is shown.
  `IAT_ASSERT(a_excl, clk, rst, !(req_ready && rsp_valid), "ready while result pending")
  // A shown result stays until taken.
  `IAT_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result dropped")
  // Accepting a request closes the input until the result is taken.
  `IAT_ASSERT_NEXT(a_busy, clk, rst, req_valid && req_ready, !req_ready, "took two requests")
  // Status codes stay in range.
  `IAT_ASSERT(a_status, clk, rst, !rsp_valid || rsp_payload.status <= ST_NOTFOUND, "bad status")
endmodule

bind ipv6_interface_address_table iat_checker u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_payload(rsp.payload)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import iat_pkg::*;

  localparam int NIF = 4;
  localparam int NSLOT = 4;
  localparam int RAND_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iat_req_if req ();
  iat_rsp_if rsp ();

  ipv6_interface_address_table #(.IF_COUNT(NIF), .ADDR_SLOTS(NSLOT)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [7:0] shadow_link [NIF];
  logic [63:0] shadow_hi [NIF*NSLOT];
  logic [63:0] shadow_lo [NIF*NSLOT];
  logic [2:0] shadow_fl [NIF*NSLOT];

  rsp_t pending_rsp [$];
  int errors = 0;
  int sent = 0;
  int taken = 0;
  int cycles = 0;
  bit hold_start = 0;
  bit hold_rsp = 0;
  bit stim_done = 0;
  int op_count [16];

  function automatic bit is_mc(logic [63:0] h);
    return h[63:56] == 8'hff;
  endfunction

  function automatic int lead_zero(logic [63:0] x);
    int n;
    n = 0;
    while (n < 64 && x[63-n] == 1'b0) n++;
    return n;
  endfunction

  function automatic int match_len(int s, logic [63:0] h, logic [63:0] l);
    logic [63:0] xh;
    xh = shadow_hi[s] ^ h;
    if (xh != 0) return lead_zero(xh);
    return 64 + lead_zero(shadow_lo[s] ^ l);
  endfunction

  function automatic int slot_of(int i, logic [63:0] h, logic [63:0] l);
    for (int k = 0; k < NSLOT; k++)
      if (shadow_hi[i*NSLOT+k] == h && shadow_lo[i*NSLOT+k] == l) return k;
    return -1;
  endfunction

  function automatic int longest_on(int i, logic [63:0] h, logic [63:0] l, bit with_mc,
                                    ref int sl);
    int best;
    int m;
    int s;
    best = 0;
    for (int k = 0; k < NSLOT; k++) begin
      s = i*NSLOT + k;
      if (shadow_hi[s] == 0 && shadow_lo[s] == 0) continue;
      if (!with_mc && is_mc(shadow_hi[s])) continue;
      m = match_len(s, h, l);
      if (m > best) begin
        best = m;
        sl = k;
      end
    end
    return best;
  endfunction

  function automatic void clear_iface(int i);
    shadow_link[i] = 0;
    for (int k = 0; k < NSLOT; k++) begin
      shadow_hi[i*NSLOT+k] = 0;
      shadow_lo[i*NSLOT+k] = 0;
      shadow_fl[i*NSLOT+k] = 0;
    end
  endfunction

  // Applies one request to the shadow table and returns the answer it gives.
  function automatic rsp_t table_answer(req_t q);
    rsp_t r;
    bit ready_if;
    bit unspec;
    bit loop;
    int k;
    int s;
    int sl;
    int m;
    int best;
    r = '0;
    r.status = ST_OK;
    ready_if = q.if_index < NIF && shadow_link[q.if_index] != 0;
    unspec = q.addr_high == 0 && q.addr_low == 0;
    loop = q.addr_high == 0 && q.addr_low == 1;
    case (q.func)
      FN_BIND: begin
        if (q.link_id == 0) r.status = ST_INVAL;
        else begin
          r.status = ST_NOBUF;
          for (int i = 0; i < NIF; i++) begin
            if (shadow_link[i] == q.link_id) begin
              r.status = ST_BOUND;
              break;
            end
            if (shadow_link[i] == 0) begin
              shadow_link[i] = q.link_id;
              r.status = ST_OK;
              r.hit_if = 3'(i);
              break;
            end
          end
        end
      end
      FN_RESET_IF: begin
        if (!ready_if) r.status = ST_NOTFOUND;
        else clear_iface(q.if_index);
      end
      FN_ID_BY_LINK: begin
        r.status = ST_NOTFOUND;
        if (q.link_id != 0)
          for (int i = 0; i < NIF; i++)
            if (shadow_link[i] == q.link_id) begin
              r.status = ST_OK;
              r.hit_if = 3'(i);
              break;
            end
      end
      FN_ADD: begin
        if (!ready_if) r.status = ST_NOTFOUND;
        else if (unspec || loop || (is_mc(q.addr_high) && q.is_anycast)) r.status = ST_INVAL;
        else begin
          r.status = ST_NOBUF;
          for (k = 0; k < NSLOT; k++) begin
            s = q.if_index*NSLOT + k;
            if (shadow_hi[s] == 0 && shadow_lo[s] == 0) begin
              shadow_hi[s] = q.addr_high;
              shadow_lo[s] = q.addr_low;
              if (q.is_anycast) shadow_fl[s] |= FL_ANYCAST;
              if (is_mc(q.addr_high)) shadow_fl[s] |= FL_MULTICAST;
              if (q.addr_high[63:54] == 10'h3fa) shadow_fl[s] |= FL_LINK_LOCAL;
              r.status = ST_OK;
              r.hit_slot = 3'(k);
              break;
            end
            if (shadow_hi[s] == q.addr_high && shadow_lo[s] == q.addr_low) begin
              r.status = ST_OK;
              r.hit_slot = 3'(k);
              break;
            end
          end
        end
      end
      FN_REMOVE: begin
        if (!ready_if) r.status = ST_NOTFOUND;
        else begin
          k = slot_of(q.if_index, q.addr_high, q.addr_low);
          if (k >= 0) begin
            s = q.if_index*NSLOT + k;
            shadow_hi[s] = 0;
            shadow_lo[s] = 0;
            shadow_fl[s] = 0;
            r.hit_slot = 3'(k);
          end
        end
      end
      FN_FIND_ALL: begin
        if (unspec) r.status = ST_NOTFOUND;
        else if (loop) begin
          r.loopback_hit = 1;
          r.hit_addr_low = 64'd1;
        end else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < NIF; i++) begin
            k = slot_of(i, q.addr_high, q.addr_low);
            if (k >= 0) begin
              r.status = ST_OK;
              r.hit_if = 3'(i);
              r.hit_slot = 3'(k);
              r.hit_addr_high = q.addr_high;
              r.hit_addr_low = q.addr_low;
              break;
            end
          end
        end
      end
      FN_FIND_IF: begin
        k = -1;
        if (ready_if && !unspec && !loop) k = slot_of(q.if_index, q.addr_high, q.addr_low);
        if (k < 0) r.status = ST_NOTFOUND;
        else begin
          r.hit_if = q.if_index;
          r.hit_slot = 3'(k);
          r.hit_addr_high = q.addr_high;
          r.hit_addr_low = q.addr_low;
        end
      end
      FN_PFX_IF, FN_SRC_IF: begin
        sl = 0;
        if (!ready_if) r.status = ST_NOTFOUND;
        else begin
          m = longest_on(q.if_index, q.addr_high, q.addr_low, q.func == FN_PFX_IF, sl);
          if (m == 0) r.status = ST_NOTFOUND;
          else begin
            s = q.if_index*NSLOT + sl;
            r.hit_if = q.if_index;
            r.hit_slot = 3'(sl);
            r.prefix_len = 8'(m);
            r.hit_addr_high = shadow_hi[s];
            r.hit_addr_low = shadow_lo[s];
          end
        end
      end
      FN_PFX_ALL, FN_SRC_ALL: begin
        best = 0;
        for (int i = 0; i < NIF; i++) begin
          sl = 0;
          m = longest_on(i, q.addr_high, q.addr_low, q.func == FN_PFX_ALL, sl);
          if (m > best) begin
            best = m;
            r.hit_if = 3'(i);
            r.hit_slot = 3'(sl);
          end
        end
        if (best == 0) begin
          r.status = ST_NOTFOUND;
          r.hit_if = 0;
          r.hit_slot = 0;
        end else begin
          s = r.hit_if*NSLOT + r.hit_slot;
          r.prefix_len = 8'(best);
          r.hit_addr_high = shadow_hi[s];
          r.hit_addr_low = shadow_lo[s];
        end
      end
      default: r.status = ST_INVAL;
    endcase
    return r;
  endfunction

  // Request driver; changes inputs on the falling edge only.
  task automatic send_item(req_t q, int gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.payload <= q;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(table_answer(q));
    op_count[q.func]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_all();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Addresses drawn from a small pool so that adds, finds and removes collide.
  function automatic logic [127:0] pick_addr();
    logic [127:0] a;
    case ($urandom_range(0, 9))
      0: a = {64'h0, 64'h0};
      1: a = {64'h0, 64'h1};
      2: a = {8'hff, 52'h0, 4'($urandom_range(0, 3)), 64'($urandom_range(0, 3))};
      3: a = {10'h3fa, 54'h0, 64'($urandom_range(1, 4))};
      4: a = {$urandom(), $urandom(), $urandom(), $urandom()};
      default: a = {16'h2001, 44'h0, 4'($urandom_range(0, 3)), 62'h0, 2'($urandom_range(0, 3))};
    endcase
    if ($urandom_range(0, 7) == 0) a[$urandom_range(0, 127)] ^= 1'b1;
    return a;
  endfunction

  function automatic req_t random_req();
    req_t q;
    logic [127:0] a;
    a = pick_addr();
    q.func = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(11, 15)) :
             4'($urandom_range(0, 10));
    if ($urandom_range(0, 3) == 0) q.func = FN_ADD;
    q.if_index = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) :
                 3'($urandom_range(0, 3));
    q.link_id = ($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 6));
    q.addr_high = a[127:64];
    q.addr_low = a[63:0];
    q.is_anycast = 1'($urandom_range(0, 1));
    if (q.func == FN_RESET_IF && $urandom_range(0, 3) != 0) q.func = FN_FIND_ALL;
    return q;
  endfunction

  typedef struct {
    req_t q;
    bit known;
    rsp_t want;
  } stim_row_t;

  stim_row_t plan [$];

  function automatic req_t mk(logic [3:0] f, logic [2:0] ifx, logic [7:0] lid,
                              logic [63:0] h, logic [63:0] l, logic anyc);
    req_t q;
    q.func = f;
    q.if_index = ifx;
    q.link_id = lid;
    q.addr_high = h;
    q.addr_low = l;
    q.is_anycast = anyc;
    return q;
  endfunction

  function automatic rsp_t st(logic [2:0] s);
    rsp_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic void row(req_t q, bit known = 0, rsp_t want = '0);
    stim_row_t e;
    e.q = q;
    e.known = known;
    e.want = want;
    plan.push_back(e);
  endfunction

  // Stimulus.
  initial begin
    rsp_t lb;
    req.valid = 1'b0;
    req.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    lb = st(ST_OK);
    lb.loopback_hit = 1;
    lb.hit_addr_low = 64'd1;
    // Directed table: empty table, extremes, bind limits and special addresses.
    row(mk(FN_BIND, 0, 8'd0, 0, 0, 0), 1, st(ST_INVAL));
    row(mk(FN_ADD, 0, 8'd0, 64'h2001, 0, 0), 1, st(ST_NOTFOUND));
    row(mk(FN_PFX_ALL, 0, 0, '1, '1, 0), 1, st(ST_NOTFOUND));
    row(mk(FN_FIND_ALL, 0, 0, 0, 64'd1, 0), 1, lb);
    row(mk(FN_FIND_ALL, 0, 0, 0, 0, 0), 1, st(ST_NOTFOUND));
    row(mk(4'd15, 7, 8'hff, '1, '1, 1), 1, st(ST_INVAL));
    row(mk(FN_BIND, 0, 8'hff, 0, 0, 0));
    row(mk(FN_BIND, 0, 8'hff, 0, 0, 0), 1, st(ST_BOUND));
    row(mk(FN_BIND, 0, 8'd1, 0, 0, 0));
    row(mk(FN_BIND, 0, 8'd2, 0, 0, 0));
    row(mk(FN_BIND, 0, 8'd3, 0, 0, 0));
    row(mk(FN_BIND, 0, 8'd4, 0, 0, 0), 1, st(ST_NOBUF));
    row(mk(FN_ID_BY_LINK, 0, 8'd3, 0, 0, 0));
    row(mk(FN_ADD, 7, 8'd0, 64'h2001, 0, 0), 1, st(ST_NOTFOUND));
    row(mk(FN_ADD, 0, 0, 0, 0, 0), 1, st(ST_INVAL));
    row(mk(FN_ADD, 0, 0, 0, 64'd1, 0), 1, st(ST_INVAL));
    row(mk(FN_ADD, 0, 0, 64'hff02_0000_0000_0000, 64'd1, 1), 1, st(ST_INVAL));
    row(mk(FN_ADD, 0, 0, 64'hff02_0000_0000_0000, 64'd1, 0));
    row(mk(FN_ADD, 0, 0, 64'hfe80_0000_0000_0000, 64'd5, 1));
    row(mk(FN_ADD, 0, 0, '1, '1, 0));
    row(mk(FN_ADD, 0, 0, 64'h2001_0db8_0000_0000, '1, 0));
    row(mk(FN_ADD, 0, 0, 64'h2001_0db8_0000_0001, 64'd9, 0), 1, st(ST_NOBUF));
    row(mk(FN_PFX_IF, 0, 0, 64'hff02_0000_0000_0000, 64'd1, 0));
    row(mk(FN_SRC_ALL, 0, 0, 64'hff02_0000_0000_0000, 64'd1, 0));
    row(mk(FN_FIND_IF, 0, 0, 0, 64'd1, 0), 1, st(ST_NOTFOUND));
    row(mk(FN_REMOVE, 0, 0, '1, '1, 0));
    row(mk(FN_RESET_IF, 1, 0, 0, 0, 0));

    foreach (plan[n]) begin
      send_item(plan[n].q, $urandom_range(0, 3));
      // Known answers replace the prediction, so a broken shadow table shows up too.
      if (plan[n].known) begin
        if (pending_rsp[$] != plan[n].want) begin
          $display("%0t: table row %0d: expected %h, predicted %h", $time, n,
                   plan[n].want, pending_rsp[$]);
          errors++;
        end
        pending_rsp[$] = plan[n].want;
      end
    end
    drain_all();

    // Random requests, with a long response stall once and a drain pause once.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 300) hold_start = 1;
      if (n == 900) drain_all();
      send_item(random_req(), (n % 200 < 40) ? 0 : $urandom_range(0, 14));
    end
    req.valid <= 1'b0;
    stim_done = 1;
  end

  // Long hold-off on the response side, counted here.
  initial begin
    wait (hold_start);
    hold_rsp = 1;
    repeat (400) @(negedge clk);
    hold_rsp = 0;
  end

  // Response side: random stalls, samples at the rising edge.
  initial begin
    int stall;
    rsp_t want;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ((taken % 200) < 40) ? 0 : $urandom_range(0, 14);
      if (stall > 0 || hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (hold_rsp) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      taken++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected item %h", $time, rsp.payload);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.payload.status !== want.status ||
            rsp.payload.hit_if !== want.hit_if ||
            rsp.payload.hit_slot !== want.hit_slot ||
            rsp.payload.hit_addr_high !== want.hit_addr_high ||
            rsp.payload.hit_addr_low !== want.hit_addr_low ||
            rsp.payload.prefix_len !== want.prefix_len ||
            rsp.payload.loopback_hit !== want.loopback_hit) begin
          $display("%0t: mismatch: expected %h, actual %h", $time, want, rsp.payload);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Cycle count and end of run.
  initial begin
    @(posedge clk);
    while (!(stim_done && pending_rsp.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("ipv6_interface_address_table regression: fail");
      $finish;
    end else begin
      repeat (40) @(posedge clk);
      $display("Run covered %0d requests (%0d bind, %0d add, %0d prefix or source searches),",
               sent, op_count[FN_BIND], op_count[FN_ADD],
               op_count[FN_PFX_IF] + op_count[FN_PFX_ALL] + op_count[FN_SRC_IF] +
               op_count[FN_SRC_ALL]);
      $display("with %0d answers checked and %0d errors.", taken, errors);
      if (errors == 0) $display("ipv6_interface_address_table regression: pass");
      else $display("ipv6_interface_address_table regression: fail");
      $finish;
    end
  end
endmodule
